// File: design/mdioc22_pkg.sv
`default_nettype none

package mdioc22_pkg;

   // Default preamble length in MDC periods.
   localparam int PREAMBLE_BITS_DEFAULT = 32;

   // Frame body lengths after the preamble.
   localparam int READ_HEAD_BITS   = 14;
   localparam int READ_SAMPLE_BITS = 18;
   localparam int WRITE_BODY_BITS  = 32;

   // Period counter width; it holds the longest frame, 32 + 32 periods.
   localparam int COUNT_W = 7;

   // Fixed frame bits: start 01 and read opcode 10, and for a write start 01,
   // opcode 01 and turnaround 10.
   localparam logic [3:0]  READ_HEAD    = 4'b0110;
   localparam logic [31:0] WRITE_FRAME  = 32'h5002_0000;

   // Beat widths on the stream ports.
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 24;

   // Item kinds carried on the request tuser.
   typedef enum logic [1:0] {
      ACTION_TICK  = 2'd0,
      ACTION_READ  = 2'd1,
      ACTION_WRITE = 2'd2
   } action_type;

   // One request item.
   typedef struct packed {
      logic [1:0]  action;
      logic [4:0]  phy_address;
      logic [4:0]  register_address;
      logic [15:0] write_data;
      logic        mdio_in;
   } req_item_type;

   // One result item.
   typedef struct packed {
      logic        mdio_out;
      logic        mdio_drive;
      logic        busy_res;
      logic        done_res;
      logic [15:0] read_data;
      logic        start_refused;
   } rsp_item_type;

endpackage

`default_nettype wire

// File: design/mdio_clause22_management_master.sv
`default_nettype none
// A request beat passes through the input register, then the result register.
// Throughput: one beat per cycle unless rsp_tready stalls the result register;
// each register holds one item, and the frame sequencer handles one item per step.
// Reset: synchronous, active high; clears the pipeline and all frame state,
// leaving the master idle with the line released.

module mdio_clause22_management_master import mdioc22_pkg::*; #(
   parameter int PREAMBLE_BITS = PREAMBLE_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   // [4:0] phy_address, [9:5] register_address, [25:10] write_data,
   // [26] mdio_in, [31:27] zero
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // [1:0] action
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [0] mdio_out, [1] mdio_drive, [2] busy_res, [3] done_res,
   // [19:4] read_data, [20] start_refused, [23:21] zero
   output      logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type core_result;
   logic         advance;

   // The input register moves on when the result register is free or draining.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.action           <= req_tuser[1:0];
         in_item_ff.phy_address      <= req_tdata[4:0];
         in_item_ff.register_address <= req_tdata[9:5];
         in_item_ff.write_data       <= req_tdata[25:10];
         in_item_ff.mdio_in          <= req_tdata[26];
      end
   end

   mdioc22_core #(
      .PREAMBLE_BITS (PREAMBLE_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (core_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0,
                        out_item_ff.start_refused,
                        out_item_ff.read_data,
                        out_item_ff.done_res,
                        out_item_ff.busy_res,
                        out_item_ff.mdio_drive,
                        out_item_ff.mdio_out};

endmodule

`default_nettype wire

// File: design/mdioc22_core.sv
`default_nettype none

module mdioc22_core import mdioc22_pkg::*; #(
   parameter int PREAMBLE_BITS = PREAMBLE_BITS_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire req_item_type item,
   output rsp_item_type      result
);

   localparam logic [COUNT_W-1:0] PRE_END  = COUNT_W'(PREAMBLE_BITS);
   localparam logic [COUNT_W-1:0] HEAD_END = COUNT_W'(PREAMBLE_BITS + READ_HEAD_BITS);
   localparam logic [COUNT_W-1:0] READ_END =
      COUNT_W'(PREAMBLE_BITS + READ_HEAD_BITS + READ_SAMPLE_BITS);
   localparam logic [COUNT_W-1:0] WRITE_END = COUNT_W'(PREAMBLE_BITS + WRITE_BODY_BITS);

   logic [31:0]        frame_shift_ff,   frame_shift_in;
   logic [COUNT_W-1:0] period_count_ff,  period_count_in;
   logic               read_ff,          read_in;
   logic               active_ff,        active_in;
   logic [15:0]        capture_shift_ff, capture_shift_in;

   logic [COUNT_W-1:0] count_next;
   logic [COUNT_W-1:0] total_periods;

   assign count_next    = period_count_ff + COUNT_W'(1);
   assign total_periods = read_ff ? READ_END : WRITE_END;

   // Frame sequencer: one request item per step.
   always_comb begin
      frame_shift_in   = frame_shift_ff;
      period_count_in  = period_count_ff;
      read_in          = read_ff;
      active_in        = active_ff;
      capture_shift_in = capture_shift_ff;
      result           = '0;

      unique case (item.action)
         ACTION_READ, ACTION_WRITE: begin
            if (active_ff) begin
               result.start_refused = 1'b1;
            end else begin
               if (item.action == ACTION_READ) begin
                  frame_shift_in = {READ_HEAD, item.phy_address, item.register_address,
                                    18'd0};
                  read_in        = 1'b1;
               end else begin
                  frame_shift_in = WRITE_FRAME
                                 | {4'd0, item.phy_address, item.register_address, 18'd0}
                                 | {16'd0, item.write_data};
                  read_in        = 1'b0;
               end
               active_in        = 1'b1;
               period_count_in  = '0;
               capture_shift_in = '0;
            end
         end
         ACTION_TICK: begin
            if (active_ff) begin
               // Preamble ones, then driven frame bits, then for a read sampling periods.
               priority if (period_count_ff < PRE_END) begin
                  result.mdio_out   = 1'b1;
                  result.mdio_drive = 1'b1;
               end else if (!read_ff || period_count_ff < HEAD_END) begin
                  result.mdio_out   = frame_shift_ff[31];
                  result.mdio_drive = 1'b1;
                  frame_shift_in    = {frame_shift_ff[30:0], 1'b0};
               end else begin
                  capture_shift_in = {capture_shift_ff[14:0], item.mdio_in};
               end
               period_count_in = count_next;
               if (count_next >= total_periods) begin
                  result.done_res = 1'b1;
                  active_in       = 1'b0;
                  if (read_ff) begin
                     result.read_data = capture_shift_in;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      result.busy_res = active_in;
   end

   // Transaction state, updated once per processed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_shift_ff   <= '0;
         period_count_ff  <= '0;
         read_ff          <= 1'b0;
         active_ff        <= 1'b0;
         capture_shift_ff <= '0;
      end else if (step) begin
         frame_shift_ff   <= frame_shift_in;
         period_count_ff  <= period_count_in;
         read_ff          <= read_in;
         active_ff        <= active_in;
         capture_shift_ff <= capture_shift_in;
      end
   end

endmodule

`default_nettype wire
